/* sv/rate_and_group_size_scheduler_top_defines.svh */
// Assertion macros for the rate and group size scheduler.
// Included by files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef RATE_AND_GROUP_SIZE_SCHEDULER_TOP_DEFINES_SVH
`define RATE_AND_GROUP_SIZE_SCHEDULER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define RGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RGS_ASSERT_IMP(lbl, ante, cons, msg)
`define RGS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/rgs_pkg.sv */
// Shared types, codes and constants of the rate and group size scheduler.
// No dependencies.
`default_nettype none
package rgs_pkg;
	localparam int NODES_DEF = 8;
	localparam int BINS_DEF = 4;
	localparam int DIV_NW = 40;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] RXN_LIMIT = 32'h0005_0000;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [31:0] MIN_GAP_MS = 32'd100;
	localparam logic [16:0] ONE_Q16_17 = 17'h1_0000;
	localparam logic [16:0] KEEP_Q16 = 17'd13107;
	localparam logic [16:0] NEW_Q16 = 17'd52429;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_OFFLINE = 2'd1;
	localparam logic [1:0] OP_LIVE = 2'd2;
	localparam logic [1:0] OP_TIMER = 2'd3;

	localparam logic [2:0] CFG_CORE_BUDGET = 3'd0;
	localparam logic [2:0] CFG_NODE_COUNT = 3'd1;
	localparam logic [2:0] CFG_MAX_GROUP = 3'd2;
	localparam logic [2:0] CFG_TOTAL_NODE_CORES = 3'd3;
	localparam logic [2:0] CFG_PLAN_MEDIAN = 3'd4;
	localparam logic [2:0] CFG_SAFETY_MARGIN = 3'd5;
	localparam logic [2:0] CFG_CHANGE_THRESHOLD = 3'd6;
	localparam logic [2:0] CFG_START_RATE = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] node_index;
		logic [31:0] median_time;
		logic [31:0] tail_time;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic applied;
		logic [2:0] grp_size;
		logic [31:0] rate;
	} out_item_t;

	typedef struct packed {
		logic [6:0] core_budget;
		logic [3:0] node_count;
		logic [2:0] max_group;
		logic [7:0] total_node_cores;
		logic plan_on_median;
		logic [15:0] safety_margin;
		logic [15:0] change_threshold;
		logic [31:0] start_rate;
	} cfg_t;

	typedef enum logic [4:0] {
		DP_NONE, DP_LOAD, DP_WRITE, DP_START, DP_STEP, DP_PLAN_INIT, DP_GROUP_INIT,
		DP_SUM, DP_DIV_K, DP_DIV_RATE, DP_DIV_INV, DP_DIV_RXN, DP_PICK,
		DP_MUL_SC, DP_MUL_LIM, DP_MUL_KEEP, DP_MUL_NEW
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic out_load;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic grp_lt_mb;
		logic loop_empty;
		logic sum_done;
		logic div_done;
		logic g_last;
		logic go;
	} dp_stat_t;
endpackage
`default_nettype wire

/* sv/rate_and_group_size_scheduler_top.sv */
// Top level of the rate and group size scheduler: config registers, output register,
// controller and datapath. Depends on rgs_pkg, rgs_ctrl, rgs_dp and the defines header.
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  in_data    (rgs_pkg::in_item_t)
// out      source     out_valid / out_stall out_data  (rgs_pkg::out_item_t)
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Requests are a start, an offline table write, a timer step and a live re-plan; a
// re-plan walks the group sizes, and each group size runs four divisions on the one
// shared divider. A stalled output register holds the finish.
// Reset clears the tables through per-entry valid bits, no clearing pass.
// A finished request waits in the output register; the next one is taken meanwhile.
`default_nettype none
`include "rate_and_group_size_scheduler_top_defines.svh"
module rate_and_group_size_scheduler_top #(
	parameter int NODES = rgs_pkg::NODES_DEF,
	parameter int BINS = rgs_pkg::BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  rgs_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rgs_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import rgs_pkg::*;

	cfg_t cfg_q;
	dp_ctl_t ctl;
	dp_stat_t stat;
	out_item_t res, out_data_q;
	logic out_valid_q, out_free, idle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.core_budget <= 7'd4;
			cfg_q.node_count <= 4'd8;
			cfg_q.max_group <= 3'd1;
			cfg_q.total_node_cores <= 8'd8;
			cfg_q.plan_on_median <= 1'b1;
			cfg_q.safety_margin <= 16'd0;
			cfg_q.change_threshold <= 16'd6554;
			cfg_q.start_rate <= 32'd655360;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CORE_BUDGET: cfg_q.core_budget <= cfg_data[6:0];
				CFG_NODE_COUNT: cfg_q.node_count <= cfg_data[3:0];
				CFG_MAX_GROUP: cfg_q.max_group <= cfg_data[2:0];
				CFG_TOTAL_NODE_CORES: cfg_q.total_node_cores <= cfg_data[7:0];
				CFG_PLAN_MEDIAN: cfg_q.plan_on_median <= cfg_data[0];
				CFG_SAFETY_MARGIN: cfg_q.safety_margin <= cfg_data[15:0];
				CFG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data[15:0];
				CFG_START_RATE: cfg_q.start_rate <= cfg_data;
			endcase
		end
	end

	rgs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_free(out_free),
		.stat(stat),
		.ctl(ctl),
		.idle(idle)
	);

	rgs_dp #(.NODES(NODES), .BINS(BINS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg(cfg_q),
		.ctl(ctl),
		.stat(stat),
		.res(res)
	);

	assign in_stall = !idle;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`RGS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
	`RGS_ASSERT_IMP(a_load_into_free, ctl.out_load, out_free, "waiting result overwritten")
	`RGS_ASSERT_IMP(a_group_nonzero, out_valid, out_data.grp_size != 3'd0, "group size zero")
endmodule
`default_nettype wire

/* sv/rgs_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturates to 32 bits.
// Depends on rgs_pkg.
`default_nettype none
module rgs_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rgs_pkg::DIV_NW-1:0] num,
	input  logic [31:0] den,
	output logic done,
	output logic [31:0] quo
);
	import rgs_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q, quo_q;
	logic [31:0] den_q, rem_q, rem_nx;
	logic [32:0] rem_sh;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_NW-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = (|quo_q[DIV_NW-1:32]) ? SAT32 : quo_q[31:0];
endmodule
`default_nettype wire

/* sv/rgs_dp.sv */
// Datapath: live time tables, plan registers, shared divider and multiplier.
// Depends on rgs_pkg and rgs_div.
`default_nettype none
module rgs_dp #(
	parameter int NODES = rgs_pkg::NODES_DEF,
	parameter int BINS = rgs_pkg::BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rgs_pkg::in_item_t in_data,
	input  rgs_pkg::cfg_t cfg,
	input  rgs_pkg::dp_ctl_t ctl,
	output rgs_pkg::dp_stat_t stat,
	output rgs_pkg::out_item_t res
);
	import rgs_pkg::*;

	localparam int DEPTH = BINS * NODES;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(NODES + 1);
	localparam int SW = 32 + NW;

	in_item_t item_q;
	logic [2:0] cur_g_q, g_q, lim_g_q, best_g_q, mb;
	logic [31:0] cur_rate_q, last_ms_q;
	logic applied_q;

	logic [63:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [63:0] rd_s1;
	logic rdv_s1, pend_s1;

	logic full_q, full_c;
	logic [NW-1:0] idx_q, ncnt;
	logic [SW-1:0] sum_q;
	logic [31:0] mx_q, s_q, r_q, x_q, best_x_q, best_r_q, sc_q, lim_q;
	logic [6:0] k_q;
	logic [48:0] prod_q, acc_q;
	dp_op_t ptag_q, div_sel_q;

	logic [AW-1:0] wa, ra;
	logic we, rd_en;
	logic [31:0] rd_val, sum_sat, diff, elapsed, div_den, div_quo, mul_a;
	logic [16:0] mul_b;
	logic [DIV_NW-1:0] div_num;
	logic div_start, div_done, is_mul;
	logic [32:0] x_sum;
	logic [49:0] mix;

	always_comb begin
		if (cfg.max_group == 3'd0) mb = 3'd1;
		else if (32'(cfg.max_group) > BINS) mb = 3'(BINS);
		else mb = cfg.max_group;
		ncnt = (32'(cfg.node_count) > NODES) ? NW'(NODES) : NW'(cfg.node_count);
		full_c = {1'b0, cfg.core_budget} >= cfg.total_node_cores;
		wa = AW'((32'(cur_g_q) - 32'd1) * NODES + 32'(item_q.node_index));
		ra = AW'((32'(g_q) - 32'd1) * NODES + 32'(idx_q));
		we = (ctl.op == DP_WRITE) && (32'(item_q.node_index) < NODES);
		rd_en = (ctl.op == DP_SUM) && (idx_q < ncnt);
		rd_val = rdv_s1 ? (cfg.plan_on_median ? rd_s1[31:0] : rd_s1[63:32]) : 32'd0;
		sum_sat = (|sum_q[SW-1:32]) ? SAT32 : sum_q[31:0];
		diff = (sc_q > cur_rate_q) ? sc_q - cur_rate_q : cur_rate_q - sc_q;
		elapsed = item_q.now_ms - last_ms_q;
		x_sum = {1'b0, s_q} + {1'b0, div_quo};
		mix = {1'b0, acc_q} + {1'b0, prod_q};
	end

	always_comb begin
		div_start = 1'b1;
		div_num = '0;
		div_den = '0;
		unique case (ctl.op)
			DP_DIV_K: begin
				div_num = full_q ? DIV_NW'(cfg.node_count) : DIV_NW'(cfg.core_budget);
				div_den = full_q ? 32'd1 : 32'(g_q);
			end
			DP_DIV_RATE: begin
				div_num = DIV_NW'({k_q, 32'd0});
				div_den = sum_sat;
			end
			DP_DIV_INV: begin
				div_num = DIV_NW'({1'b1, 32'd0});
				div_den = mx_q;
			end
			DP_DIV_RXN: begin
				div_num = DIV_NW'({1'b1, 32'd0});
				div_den = r_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		is_mul = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.op)
			DP_MUL_SC: begin
				mul_a = best_r_q;
				mul_b = ONE_Q16_17 - {1'b0, cfg.safety_margin};
			end
			DP_MUL_LIM: begin
				mul_a = cur_rate_q;
				mul_b = {1'b0, cfg.change_threshold};
			end
			DP_MUL_KEEP: begin
				mul_a = cur_rate_q;
				mul_b = KEEP_Q16;
			end
			DP_MUL_NEW: begin
				mul_a = sc_q;
				mul_b = NEW_Q16;
			end
			default: is_mul = 1'b0;
		endcase
	end

	rgs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_g_q <= 3'd1;
			cur_rate_q <= '0;
			last_ms_q <= '0;
			applied_q <= 1'b0;
			vld_q <= '0;
			rdv_s1 <= 1'b0;
			pend_s1 <= 1'b0;
			ptag_q <= DP_NONE;
		end else begin
			pend_s1 <= rd_en;
			rdv_s1 <= vld_q[ra];
			ptag_q <= is_mul ? ctl.op : DP_NONE;
			if (we) vld_q[wa] <= 1'b1;
			if (ctl.op == DP_LOAD) applied_q <= 1'b0;
			if (ctl.op == DP_START) cur_rate_q <= cfg.start_rate;
			if (ctl.op == DP_STEP) begin
				cur_g_q <= cur_g_q + 3'd1;
				last_ms_q <= item_q.now_ms;
				applied_q <= 1'b1;
			end
			if (ptag_q == DP_MUL_NEW) begin
				cur_rate_q <= mix[47:16];
				cur_g_q <= best_g_q;
				last_ms_q <= item_q.now_ms;
				applied_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= {item_q.tail_time, item_q.median_time};
		rd_s1 <= mem_q[ra];
		if (ctl.op == DP_LOAD) item_q <= in_data;
		if (is_mul) prod_q <= mul_a * mul_b;
		if (div_start) div_sel_q <= ctl.op;
		if (ctl.op == DP_DIV_RATE) s_q <= sum_sat;
		if (rd_en) idx_q <= idx_q + 1'b1;
		if (pend_s1) begin
			sum_q <= sum_q + SW'(rd_val);
			if (rd_val > mx_q) mx_q <= rd_val;
		end
		unique case (ptag_q)
			DP_MUL_SC: sc_q <= prod_q[47:16];
			DP_MUL_LIM: lim_q <= prod_q[47:16];
			DP_MUL_KEEP: acc_q <= prod_q;
			default: ;
		endcase
		if (div_done) begin
			unique case (div_sel_q)
				DP_DIV_K: k_q <= div_quo[6:0];
				DP_DIV_RATE: r_q <= div_quo;
				DP_DIV_INV: if (mx_q != 32'd0 && div_quo < r_q) r_q <= div_quo;
				DP_DIV_RXN: x_q <= x_sum[32] ? SAT32 : x_sum[31:0];
				default: ;
			endcase
		end
		unique case (ctl.op)
			DP_START: begin
				best_r_q <= cfg.start_rate;
				best_g_q <= 3'd1;
			end
			DP_PLAN_INIT: begin
				full_q <= full_c;
				best_x_q <= RXN_LIMIT;
				best_r_q <= ONE_Q16;
				best_g_q <= 3'd1;
				if (full_c) begin
					g_q <= mb;
					lim_g_q <= mb;
				end else begin
					g_q <= 3'd1;
					lim_g_q <= ({1'b0, cfg.core_budget} < {5'd0, mb}) ?
						cfg.core_budget[2:0] : mb;
				end
			end
			DP_GROUP_INIT: begin
				sum_q <= '0;
				mx_q <= '0;
				idx_q <= '0;
			end
			DP_PICK: begin
				if (full_q || x_q < best_x_q) begin
					best_x_q <= x_q;
					best_r_q <= r_q;
					best_g_q <= g_q;
				end
				g_q <= g_q + 3'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.op = item_q.op;
		stat.grp_lt_mb = cur_g_q < mb;
		stat.loop_empty = lim_g_q == 3'd0;
		stat.sum_done = (idx_q == ncnt) && !pend_s1;
		stat.div_done = div_done;
		stat.g_last = g_q == lim_g_q;
		stat.go = ((best_g_q != cur_g_q) || (diff >= lim_q)) && (elapsed >= MIN_GAP_MS);
		res.applied = applied_q;
		res.grp_size = cur_g_q;
		res.rate = cur_rate_q;
	end
endmodule
`default_nettype wire

/* sv/rgs_ctrl.sv */
// Controller: sequences table writes, the plan walk and the rate update.
// Depends on rgs_pkg.
`default_nettype none
module rgs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_free,
	input  rgs_pkg::dp_stat_t stat,
	output rgs_pkg::dp_ctl_t ctl,
	output logic idle
);
	import rgs_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_PINIT, S_PCHK, S_GINIT, S_SUM, S_DK, S_WK, S_DR, S_WR,
		S_DI, S_WI, S_DX, S_WX, S_PICK, S_MSC, S_MLIM, S_MWAIT, S_DECIDE,
		S_MKEEP, S_MNEW, S_AWAIT, S_FIN
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		ctl.op = DP_NONE;
		ctl.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				ctl.op = DP_LOAD;
				state_nx = S_DISP;
			end
			S_DISP: begin
				unique case (stat.op)
					OP_START: begin
						ctl.op = DP_START;
						state_nx = S_MSC;
					end
					OP_OFFLINE: begin
						ctl.op = DP_WRITE;
						state_nx = S_FIN;
					end
					OP_LIVE: begin
						ctl.op = DP_WRITE;
						state_nx = S_PINIT;
					end
					default: if (stat.grp_lt_mb) begin
						ctl.op = DP_STEP;
						state_nx = S_FIN;
					end else begin
						state_nx = S_PINIT;
					end
				endcase
			end
			S_PINIT: begin
				ctl.op = DP_PLAN_INIT;
				state_nx = S_PCHK;
			end
			S_PCHK: state_nx = stat.loop_empty ? S_MSC : S_GINIT;
			S_GINIT: begin
				ctl.op = DP_GROUP_INIT;
				state_nx = S_SUM;
			end
			S_SUM: begin
				ctl.op = DP_SUM;
				if (stat.sum_done) state_nx = S_DK;
			end
			S_DK: begin
				ctl.op = DP_DIV_K;
				state_nx = S_WK;
			end
			S_WK: if (stat.div_done) state_nx = S_DR;
			S_DR: begin
				ctl.op = DP_DIV_RATE;
				state_nx = S_WR;
			end
			S_WR: if (stat.div_done) state_nx = S_DI;
			S_DI: begin
				ctl.op = DP_DIV_INV;
				state_nx = S_WI;
			end
			S_WI: if (stat.div_done) state_nx = S_DX;
			S_DX: begin
				ctl.op = DP_DIV_RXN;
				state_nx = S_WX;
			end
			S_WX: if (stat.div_done) state_nx = S_PICK;
			S_PICK: begin
				ctl.op = DP_PICK;
				state_nx = stat.g_last ? S_MSC : S_GINIT;
			end
			S_MSC: begin
				ctl.op = DP_MUL_SC;
				state_nx = S_MLIM;
			end
			S_MLIM: begin
				ctl.op = DP_MUL_LIM;
				state_nx = S_MWAIT;
			end
			S_MWAIT: state_nx = S_DECIDE;
			S_DECIDE: state_nx = (stat.op == OP_LIVE && !stat.go) ? S_FIN : S_MKEEP;
			S_MKEEP: begin
				ctl.op = DP_MUL_KEEP;
				state_nx = S_MNEW;
			end
			S_MNEW: begin
				ctl.op = DP_MUL_NEW;
				state_nx = S_AWAIT;
			end
			S_AWAIT: state_nx = S_FIN;
			S_FIN: if (out_free) begin
				ctl.out_load = 1'b1;
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign idle = state_q == S_IDLE;
endmodule
`default_nettype wire
